/* rtl/ggvc_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the
// go-to-goal velocity controller. No dependencies.
`default_nettype none
package ggvc_pkg;

    // pipeline shape
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int SQRT_STEPS        = 32;

    // angle constants
    localparam logic [15:0]        TWO_PI_Q13 = 16'd51472;
    localparam logic signed [18:0] PI_Q13_S   = 19'sd25736;
    localparam logic signed [18:0] TWO_PI_S   = 19'sd51472;
    localparam logic signed [34:0] PI_Q30     = 35'sd3373259426;

    // register indexes
    localparam logic [2:0] REG_DIST_GAIN = 3'd0;
    localparam logic [2:0] REG_LIN_LIM   = 3'd1;
    localparam logic [2:0] REG_ANG_GAIN  = 3'd2;
    localparam logic [2:0] REG_ANG_LIM   = 3'd3;
    localparam logic [2:0] REG_ARRIVE    = 3'd4;
    localparam logic [2:0] REG_ALIGN     = 3'd5;

    typedef struct packed {
        logic [15:0] distance_gain;
        logic [14:0] linear_limit;
        logic [15:0] angle_gain;
        logic [14:0] angular_limit;
        logic [30:0] arrive_tolerance;
        logic [14:0] align_tolerance;
        logic [61:0] arrive_tol_sq;
    } cfg_t;

    // word travelling along the cell chain
    typedef struct packed {
        logic               valid;
        logic               op;
        logic               zero;
        logic               goal_rch;
        logic               far;
        logic [15:0]        hd;
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [34:0] z;
        logic [63:0]        v;
        logic [63:0]        res;
    } cell_t;

    // floor(atan(2^-i) * 2^30)
    function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
        logic signed [34:0] r;
        case (i)
            5'd0:    r = 35'sd843314856;
            5'd1:    r = 35'sd497837829;
            5'd2:    r = 35'sd263043836;
            5'd3:    r = 35'sd133525158;
            5'd4:    r = 35'sd67021686;
            5'd5:    r = 35'sd33543515;
            5'd6:    r = 35'sd16775850;
            5'd7:    r = 35'sd8388437;
            5'd8:    r = 35'sd4194282;
            5'd9:    r = 35'sd2097149;
            5'd10:   r = 35'sd1048575;
            5'd11:   r = 35'sd524287;
            5'd12:   r = 35'sd262143;
            5'd13:   r = 35'sd131071;
            5'd14:   r = 35'sd65535;
            5'd15:   r = 35'sd32767;
            5'd16:   r = 35'sd16383;
            5'd17:   r = 35'sd8191;
            5'd18:   r = 35'sd4095;
            5'd19:   r = 35'sd2047;
            5'd20:   r = 35'sd1023;
            5'd21:   r = 35'sd511;
            5'd22:   r = 35'sd255;
            5'd23:   r = 35'sd127;
            5'd24:   r = 35'sd63;
            5'd25:   r = 35'sd31;
            5'd26:   r = 35'sd15;
            5'd27:   r = 35'sd7;
            5'd28:   r = 35'sd3;
            5'd29:   r = 35'sd1;
            default: r = 35'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/ggvc_regs.sv */
// APB register file for the controller gains, limits and tolerances.
// Depends on ggvc_pkg.
`default_nettype none
module ggvc_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ggvc_pkg::cfg_t    cfg
);
    import ggvc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // write registers, keep tolerance square up to date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.distance_gain    <= 16'd2048;
            cfg_reg.linear_limit     <= 15'd819;
            cfg_reg.angle_gain       <= 16'd10240;
            cfg_reg.angular_limit    <= 15'd4096;
            cfg_reg.arrive_tolerance <= 31'd6554;
            cfg_reg.align_tolerance  <= 15'd410;
            cfg_reg.arrive_tol_sq    <= 62'd42954916;
        end
        else
        begin
            cfg_reg.arrive_tol_sq <= 62'(cfg_reg.arrive_tolerance) *
                                     62'(cfg_reg.arrive_tolerance);
            if (wr)
            begin
                unique case (idx)
                    REG_DIST_GAIN: cfg_reg.distance_gain    <= pwdata[15:0];
                    REG_LIN_LIM:   cfg_reg.linear_limit     <= pwdata[14:0];
                    REG_ANG_GAIN:  cfg_reg.angle_gain       <= pwdata[15:0];
                    REG_ANG_LIM:   cfg_reg.angular_limit    <= pwdata[14:0];
                    REG_ARRIVE:    cfg_reg.arrive_tolerance <= pwdata[30:0];
                    REG_ALIGN:     cfg_reg.align_tolerance  <= pwdata[14:0];
                    default:       ;
                endcase
            end
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            REG_DIST_GAIN: prdata = 32'(cfg_reg.distance_gain);
            REG_LIN_LIM:   prdata = 32'(cfg_reg.linear_limit);
            REG_ANG_GAIN:  prdata = 32'(cfg_reg.angle_gain);
            REG_ANG_LIM:   prdata = 32'(cfg_reg.angular_limit);
            REG_ARRIVE:    prdata = 32'(cfg_reg.arrive_tolerance);
            REG_ALIGN:     prdata = 32'(cfg_reg.align_tolerance);
            default:       prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/ggvc_cell.sv */
// One cell of the chain: one CORDIC vectoring step (only when STAGE < CORDIC_STAGES) and one square root step.
// Depends on ggvc_pkg.
`default_nettype none
module ggvc_cell #(
    parameter int STAGE         = 0,
    parameter int CORDIC_STAGES = ggvc_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire ggvc_pkg::cell_t din,
    output ggvc_pkg::cell_t      dout
);
    import ggvc_pkg::*;

    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * STAGE);

    cell_t              word_next;
    cell_t              word_reg;
    logic signed [35:0] xs;
    logic signed [35:0] ys;
    logic [63:0]        trial;

    // rotate toward the x axis and refine one root bit
    always_comb
    begin
        word_next = din;
        xs        = din.x >>> STAGE;
        ys        = din.y >>> STAGE;
        trial     = din.res + SQ_BIT;
        if (STAGE < CORDIC_STAGES)
        begin
            if (!din.y[35])
            begin
                word_next.x = din.x + ys;
                word_next.y = din.y - xs;
                word_next.z = din.z + atan_q30(5'(STAGE));
            end
            else
            begin
                word_next.x = din.x - ys;
                word_next.y = din.y + xs;
                word_next.z = din.z - atan_q30(5'(STAGE));
            end
        end
        if (din.v >= trial)
        begin
            word_next.v   = din.v - trial;
            word_next.res = (din.res >> 1) + SQ_BIT;
        end
        else
        begin
            word_next.res = din.res >> 1;
        end
    end

    // hand the word on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign dout = word_reg;

endmodule
`default_nettype wire

/* rtl/go_to_goal_velocity_controller_core.sv */
// Go-to-goal velocity controller top level: front end, cell chain, output.
// Depends on ggvc_pkg, ggvc_regs, ggvc_cell.
// Structure: 4 front stages, 32 chain cells and 3 back stages.
// Throughput: one word per cycle; the whole pipeline stalls only when the
// output register is full and not taken.
// Reset (rst_n, async, active low) empties the pipeline and loads defaults.
`default_nettype none
module go_to_goal_velocity_controller_core #(
    parameter int CORDIC_STAGES = ggvc_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // robot_x, robot_y, robot_heading, goal_x, goal_y, stop_x, stop_y
    input  wire logic [207:0] s_tdata,
    // operation
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // linear_cmd, angular_cmd, reached
    output logic [31:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ggvc_pkg::*;

    cfg_t cfg;
    logic en;

    ggvc_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // stage 0: differences and mapped heading
    logic               v0_reg, op0_reg;
    logic signed [32:0] gx0_reg, gy0_reg, sx0_reg, sy0_reg;
    logic [15:0]        hd0_reg;
    logic signed [31:0] rx, ry;

    assign rx = $signed(s_tdata[31:0]);
    assign ry = $signed(s_tdata[63:32]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op0_reg <= s_tuser[0];
            gx0_reg <= 33'($signed(s_tdata[111:80])) - 33'(rx);
            gy0_reg <= 33'($signed(s_tdata[143:112])) - 33'(ry);
            sx0_reg <= 33'($signed(s_tdata[175:144])) - 33'(rx);
            sy0_reg <= 33'($signed(s_tdata[207:176])) - 33'(ry);
            hd0_reg <= s_tdata[79] ? 16'(s_tdata[79:64] + TWO_PI_Q13) : s_tdata[79:64];
        end
    end

    // stage 1: magnitudes
    logic               v1_reg, op1_reg;
    logic               far1;
    logic [31:0]        ax1_reg, ay1_reg, px1_reg, py1_reg;
    logic signed [32:0] gx1_reg, gy1_reg;
    logic [15:0]        hd1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= op0_reg;
            hd1_reg <= hd0_reg;
            gx1_reg <= gx0_reg;
            gy1_reg <= gy0_reg;
            ax1_reg <= 32'(gx0_reg[32] ? -gx0_reg : gx0_reg);
            ay1_reg <= 32'(gy0_reg[32] ? -gy0_reg : gy0_reg);
            px1_reg <= 32'(sx0_reg[32] ? -sx0_reg : sx0_reg);
            py1_reg <= 32'(sy0_reg[32] ? -sy0_reg : sy0_reg);
        end
    end

    assign far1 = px1_reg[31] | py1_reg[31];

    // stage 2: squares and tolerance box
    logic               v2_reg, op2_reg, far2_reg, box2_reg;
    logic [63:0]        gsx2_reg, gsy2_reg;
    logic [61:0]        ssx2_reg, ssy2_reg;
    logic signed [32:0] gx2_reg, gy2_reg;
    logic [15:0]        hd2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg  <= op1_reg;
            hd2_reg  <= hd1_reg;
            gx2_reg  <= gx1_reg;
            gy2_reg  <= gy1_reg;
            far2_reg <= far1;
            box2_reg <= (ax1_reg <= 32'(cfg.arrive_tolerance)) &&
                        (ay1_reg <= 32'(cfg.arrive_tolerance));
            gsx2_reg <= 64'(ax1_reg) * 64'(ax1_reg);
            gsy2_reg <= 64'(ay1_reg) * 64'(ay1_reg);
            ssx2_reg <= 62'(px1_reg[30:0]) * 62'(px1_reg[30:0]);
            ssy2_reg <= 62'(py1_reg[30:0]) * 62'(py1_reg[30:0]);
        end
    end

    // stage 3: sums, arrival test and CORDIC set-up into the chain
    cell_t chain [0:SQRT_STEPS];
    cell_t head_next;
    cell_t head_reg;
    logic [64:0] gsum;

    always_comb
    begin
        gsum               = 65'(gsx2_reg) + 65'(gsy2_reg);
        head_next.valid    = v2_reg;
        head_next.op       = op2_reg;
        head_next.hd       = hd2_reg;
        head_next.far      = far2_reg;
        head_next.goal_rch = box2_reg && (gsum <= 65'(cfg.arrive_tol_sq));
        head_next.zero     = (gx2_reg == 33'sd0) && (gy2_reg == 33'sd0);
        head_next.v        = 64'(ssx2_reg) + 64'(ssy2_reg);
        head_next.res      = 64'd0;
        if (gx2_reg[32])
        begin
            head_next.x = -36'(gx2_reg);
            head_next.y = -36'(gy2_reg);
            head_next.z = gy2_reg[32] ? -PI_Q30 : PI_Q30;
        end
        else
        begin
            head_next.x = 36'(gx2_reg);
            head_next.y = 36'(gy2_reg);
            head_next.z = 35'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            head_reg.valid <= 1'b0;
        else if (en)
            head_reg <= head_next;
    end

    assign chain[0] = head_reg;

    // chain of cells
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_cell
        ggvc_cell #(.STAGE(k), .CORDIC_STAGES(CORDIC_STAGES)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .din(chain[k]), .dout(chain[k+1])
        );
    end

    // back stage 1: bearing in Q3.13 and linear product
    cell_t              tail;
    logic               f1v_reg, f1op_reg, f1rch_reg, f1far_reg;
    logic signed [17:0] b1_reg;
    logic [15:0]        f1hd_reg;
    logic [47:0]        plin1_reg;
    logic signed [34:0] zr;
    logic signed [17:0] braw;

    assign tail = chain[SQRT_STEPS];
    assign zr   = tail.z + 35'sd65536;
    assign braw = 18'(zr >>> 17);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1v_reg <= 1'b0;
        else if (en)
            f1v_reg <= tail.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1op_reg  <= tail.op;
            f1rch_reg <= tail.goal_rch;
            f1far_reg <= tail.far;
            f1hd_reg  <= tail.hd;
            if (tail.zero)
                b1_reg <= 18'sd0;
            else if (braw[17])
                b1_reg <= braw + 18'sd51472;
            else
                b1_reg <= braw;
            plin1_reg <= 48'(cfg.distance_gain) * 48'(tail.res[31:0]);
        end
    end

    // back stage 2: heading error and angular product
    logic               f2v_reg, f2op_reg, f2rch_reg, f2far_reg;
    logic signed [18:0] e2_reg;
    logic [17:0]        ae2_reg;
    logic [47:0]        plin2_reg;
    logic [33:0]        pang2_reg;
    logic signed [18:0] e1;
    logic [17:0]        ae1;

    assign e1  = 19'(b1_reg) - 19'($signed({3'b000, f1hd_reg}));
    assign ae1 = 18'(e1[18] ? -e1 : e1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f2v_reg <= 1'b0;
        else if (en)
            f2v_reg <= f1v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f2op_reg  <= f1op_reg;
            f2rch_reg <= f1rch_reg;
            f2far_reg <= f1far_reg;
            e2_reg    <= e1;
            ae2_reg   <= ae1;
            plin2_reg <= plin1_reg;
            pang2_reg <= 34'(cfg.angle_gain) * 34'(ae1);
        end
    end

    // back stage 3: saturate, pick mode, hold in output register
    logic [20:0]  amag_raw;
    logic [14:0]  amag;
    logic [31:0]  lin_raw;
    logic [14:0]  lin;
    logic         neg;
    logic [14:0]  lin_out;
    logic [15:0]  ang_out;
    logic         rch_out;
    logic [31:0]  out_reg;

    always_comb
    begin
        amag_raw = 21'(pang2_reg >> 13);
        amag     = (amag_raw > 21'(cfg.angular_limit)) ? cfg.angular_limit : amag_raw[14:0];
        lin_raw  = 32'(plin2_reg >> 16);
        if (f2far_reg)
            lin = (cfg.distance_gain != 16'd0) ? cfg.linear_limit : 15'd0;
        else
            lin = (lin_raw > 32'(cfg.linear_limit)) ? cfg.linear_limit : lin_raw[14:0];
        lin_out = 15'd0;
        ang_out = 16'd0;
        rch_out = 1'b0;
        if (!f2op_reg)
        begin
            neg = e2_reg[18];
            if (f2rch_reg)
                rch_out = 1'b1;
            else
            begin
                lin_out = lin;
                ang_out = neg ? -16'(amag) : 16'(amag);
            end
        end
        else
        begin
            // sign of the shortest turn: error wrapped into (-pi, pi]
            if (e2_reg > PI_Q13_S)
                neg = (e2_reg - TWO_PI_S) < 19'sd0;
            else if (e2_reg <= -PI_Q13_S)
                neg = (e2_reg + TWO_PI_S) < 19'sd0;
            else
                neg = e2_reg[18];
            if (ae2_reg <= 18'(cfg.align_tolerance))
                rch_out = 1'b1;
            else
                ang_out = neg ? -16'(amag) : 16'(amag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= f2v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {rch_out, ang_out, lin_out};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
`default_nettype wire
